// ----- hw/rtl/cbr_pkg.sv -----
// Shared types, constants and helpers of the cursor bitmap row packer.
`default_nettype none
package cbr_pkg;

    localparam int CURSOR_SIZE = 64;
    localparam int ROW_W       = 6;
    localparam int SIZE_W      = 7;
    localparam int HALF_W      = 64;
    localparam int PIXEL_W     = 8;

    localparam logic [HALF_W-1:0] TRANSPARENT_WORD = {(HALF_W/16){16'hAAAA}};
    localparam logic [ROW_W-1:0]  LAST_ROW_INDEX   = ROW_W'(CURSOR_SIZE - 1);

    // source byte values
    localparam logic [PIXEL_W-1:0] BYTE_COLOR1 = 8'h03;
    localparam logic [PIXEL_W-1:0] BYTE_COLOR0 = 8'h02;

    // 2-bit cursor codes
    localparam logic [1:0] CODE_COLOR0      = 2'd0;
    localparam logic [1:0] CODE_COLOR1      = 2'd1;
    localparam logic [1:0] CODE_TRANSPARENT = 2'd2;

    // register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic pix_load;    // accept a pixel into the row accumulator
        logic fill_load;   // load a transparent fill row into the output word
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic row_done;    // the next pixel completes the current row
        logic image_fill;  // ... and the image, with transparent rows still to go
        logic fill_last;   // the current row counter is the last cursor row
    } t_dp_status;

    function automatic logic [1:0] pixel_to_code(input logic [PIXEL_W-1:0] pix);
        logic [1:0] code;
        if (pix == BYTE_COLOR1) begin
            code = CODE_COLOR1;
        end else if (pix == BYTE_COLOR0) begin
            code = CODE_COLOR0;
        end else begin
            code = CODE_TRANSPARENT;
        end
        return code;
    endfunction

    // zero acts as one, anything above the cursor size saturates
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_W'(CURSOR_SIZE)) begin
            r = SIZE_W'(CURSOR_SIZE);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cursor_bitmap_to_2bpp_rows_top.sv -----
// Top level of the cursor bitmap row packer: stream ports, register port and block wiring.
`default_nettype none
// Packs a cursor image, one source byte per word in row-major order, into 64-pixel rows of
// 2-bit codes (3 gives colour 1, code 1; 2 gives colour 0, code 0; anything else gives
// transparent, code 2). Pixel p of a row lies at bits 2p+1:2p of pixels_low for p < 32 and
// at bits 2(p-32)+1:2(p-32) of pixels_high for the rest; pixels past image_width stay
// transparent. A row word leaves on the master side once image_width pixels have arrived.
// When the row numbered image_height-1 completes, the remaining rows up to 63 follow as
// fully transparent words and the next image starts again at row 0; tlast marks row 63.
// Widths and heights of 0 act as 1 and values above 64 act as 64. Rate: one pixel word per
// cycle while a row fills and the master side takes each finished row as it appears; while
// a row word waits in the single output register with m_tready low, every pixel word is
// held off. After the last image row the controller emits the trailing transparent rows
// one per cycle while the master side takes them, and the slave side stalls until the last
// of them is loaded. The single output register sets that rate: one row word can be loaded
// per cycle. Register map: image_width at byte 0, image_height at byte 4, 7 bits each, both
// reset to 64; write them only while idle.
module cursor_bitmap_to_2bpp_rows_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // slave side
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,    // [7:0] pixel_code
    // master side
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [135:0] m_tdata,    // [5:0] row_index, [69:6] pixels_low,
                                     // [133:70] pixels_high, [135:134] zero
    output logic         m_tlast,    // last_row
    // register port
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [cbr_pkg::SIZE_W-1:0] r_image_width;
    logic [cbr_pkg::SIZE_W-1:0] r_image_height;
    logic                       w_reg_write;
    logic                       w_reg_sel;

    cbr_pkg::t_dp_cmd           w_cmd;
    cbr_pkg::t_dp_status        w_status;
    logic [cbr_pkg::ROW_W-1:0]  w_row_index;
    logic [cbr_pkg::HALF_W-1:0] w_pixels_low;
    logic [cbr_pkg::HALF_W-1:0] w_pixels_high;
    logic                       w_last_row;

    // register port: zero wait states, register chosen by word address bit
    assign pready      = 1'b1;
    assign w_reg_sel   = paddr[2];
    assign w_reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= cbr_pkg::SIZE_W'(cbr_pkg::CURSOR_SIZE);
            r_image_height <= cbr_pkg::SIZE_W'(cbr_pkg::CURSOR_SIZE);
        end else if (w_reg_write) begin
            if (w_reg_sel == cbr_pkg::REG_IMAGE_WIDTH) begin
                r_image_width <= pwdata[cbr_pkg::SIZE_W-1:0];
            end else begin
                r_image_height <= pwdata[cbr_pkg::SIZE_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_sel == cbr_pkg::REG_IMAGE_WIDTH) begin
            prdata[cbr_pkg::SIZE_W-1:0] = r_image_width;
        end else begin
            prdata[cbr_pkg::SIZE_W-1:0] = r_image_height;
        end
    end

    cbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (s_tvalid),
        .o_pix_ready (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    cbr_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_pixel        (s_tdata),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_status       (w_status),
        .o_row_index    (w_row_index),
        .o_pixels_low   (w_pixels_low),
        .o_pixels_high  (w_pixels_high),
        .o_last_row     (w_last_row)
    );

    // pack the row word, row index in the lowest bits
    assign m_tdata = {2'b00, w_pixels_high, w_pixels_low, w_row_index};
    assign m_tlast = w_last_row;

    // tlast and the row index must agree
    a_last_row_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[5:0] == cbr_pkg::LAST_ROW_INDEX)))
        else $error("tlast disagrees with row index");

    // rows leave in order, wrapping after the last one
    a_row_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready) |=>
            (!m_tvalid || (m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1)))
        else $error("row index out of sequence");

    // an image end with rows still to fill holds off the next pixel
    a_fill_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.pix_load && w_status.image_fill) |=> !s_tready)
        else $error("pixel accepted during transparent fill");

endmodule
`default_nettype wire

// ----- hw/rtl/cbr_ctrl.sv -----
// Controller of the cursor bitmap row packer: pixel intake and transparent fill sequencing.
`default_nettype none
module cbr_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_pix_valid,
    output logic               o_pix_ready,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    input  wire cbr_pkg::t_dp_status i_status,
    output cbr_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic {
        S_PIXEL,
        S_FILL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    // the output word may be (re)loaded when empty or being taken this cycle
    assign w_slot_free     = !r_out_valid || i_out_ready;
    assign o_pix_ready     = (r_state == S_PIXEL) && w_slot_free;
    assign o_cmd.pix_load  = i_pix_valid && o_pix_ready;
    assign o_cmd.fill_load = (r_state == S_FILL) && w_slot_free;
    assign o_out_valid     = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if ((o_cmd.pix_load && i_status.row_done) || o_cmd.fill_load) begin
            n_out_valid = 1'b1;
        end
        case (r_state)
            S_PIXEL: begin
                if (o_cmd.pix_load && i_status.image_fill) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (o_cmd.fill_load && i_status.fill_last) begin
                    n_state = S_PIXEL;
                end
            end
            default: begin
                n_state = S_PIXEL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PIXEL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cbr_datapath.sv -----
// Datapath of the cursor bitmap row packer: counters, row accumulator and output word.
`default_nettype none
module cbr_datapath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire cbr_pkg::t_dp_cmd               i_cmd,
    input  wire [cbr_pkg::PIXEL_W-1:0]          i_pixel,
    input  wire [cbr_pkg::SIZE_W-1:0]           i_image_width,
    input  wire [cbr_pkg::SIZE_W-1:0]           i_image_height,
    output cbr_pkg::t_dp_status                 o_status,
    output logic [cbr_pkg::ROW_W-1:0]           o_row_index,
    output logic [cbr_pkg::HALF_W-1:0]          o_pixels_low,
    output logic [cbr_pkg::HALF_W-1:0]          o_pixels_high,
    output logic                                o_last_row
);

    logic [cbr_pkg::ROW_W-1:0]  r_col;
    logic [cbr_pkg::ROW_W-1:0]  r_row;
    logic [cbr_pkg::HALF_W-1:0] r_acc_lo;
    logic [cbr_pkg::HALF_W-1:0] r_acc_hi;
    logic [cbr_pkg::ROW_W-1:0]  r_out_row;
    logic [cbr_pkg::HALF_W-1:0] r_out_lo;
    logic [cbr_pkg::HALF_W-1:0] r_out_hi;
    logic                       r_out_last;

    logic [cbr_pkg::HALF_W-1:0] w_acc_lo_upd;
    logic [cbr_pkg::HALF_W-1:0] w_acc_hi_upd;
    logic [1:0]                 w_code;
    logic [cbr_pkg::SIZE_W-1:0] w_width;
    logic [cbr_pkg::SIZE_W-1:0] w_height;
    logic [cbr_pkg::SIZE_W-1:0] w_col_next;
    logic [cbr_pkg::SIZE_W-1:0] w_row_next;

    assign w_width    = cbr_pkg::clamp_size(i_image_width);
    assign w_height   = cbr_pkg::clamp_size(i_image_height);
    assign w_col_next = {1'b0, r_col} + cbr_pkg::SIZE_W'(1);
    assign w_row_next = {1'b0, r_row} + cbr_pkg::SIZE_W'(1);
    assign w_code     = cbr_pkg::pixel_to_code(i_pixel);

    assign o_status.row_done   = !(w_col_next < w_width);
    assign o_status.image_fill = o_status.row_done && !(w_row_next < w_height)
                                 && (r_row != cbr_pkg::LAST_ROW_INDEX);
    assign o_status.fill_last  = (r_row == cbr_pkg::LAST_ROW_INDEX);

    // drop the new code into its two-bit slot
    always_comb begin
        w_acc_lo_upd = r_acc_lo;
        w_acc_hi_upd = r_acc_hi;
        for (int i = 0; i < cbr_pkg::HALF_W / 2; i++) begin
            if (r_col[cbr_pkg::ROW_W-2:0] == (cbr_pkg::ROW_W-1)'(i)) begin
                if (!r_col[cbr_pkg::ROW_W-1]) begin
                    w_acc_lo_upd[2*i +: 2] = w_code;
                end else begin
                    w_acc_hi_upd[2*i +: 2] = w_code;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_acc_lo <= cbr_pkg::TRANSPARENT_WORD;
            r_acc_hi <= cbr_pkg::TRANSPARENT_WORD;
        end else if (i_cmd.pix_load) begin
            if (o_status.row_done) begin
                // row goes out; restart a transparent row and advance (wraps after the last)
                r_col    <= '0;
                r_row    <= w_row_next[cbr_pkg::ROW_W-1:0];
                r_acc_lo <= cbr_pkg::TRANSPARENT_WORD;
                r_acc_hi <= cbr_pkg::TRANSPARENT_WORD;
            end else begin
                r_col    <= w_col_next[cbr_pkg::ROW_W-1:0];
                r_acc_lo <= w_acc_lo_upd;
                r_acc_hi <= w_acc_hi_upd;
            end
        end else if (i_cmd.fill_load) begin
            r_row <= w_row_next[cbr_pkg::ROW_W-1:0];
        end
    end

    // output word, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_load && o_status.row_done) begin
            r_out_row  <= r_row;
            r_out_lo   <= w_acc_lo_upd;
            r_out_hi   <= w_acc_hi_upd;
            r_out_last <= (r_row == cbr_pkg::LAST_ROW_INDEX);
        end else if (i_cmd.fill_load) begin
            r_out_row  <= r_row;
            r_out_lo   <= cbr_pkg::TRANSPARENT_WORD;
            r_out_hi   <= cbr_pkg::TRANSPARENT_WORD;
            r_out_last <= (r_row == cbr_pkg::LAST_ROW_INDEX);
        end
    end

    assign o_row_index   = r_out_row;
    assign o_pixels_low  = r_out_lo;
    assign o_pixels_high = r_out_hi;
    assign o_last_row    = r_out_last;

endmodule
`default_nettype wire
